[design/unsorted_array_priority_queue_unit_defines.svh]
// ----------------------------------------------------------------------------
// Unsorted array priority queue - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UNSORTED_ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define UNSORTED_ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Check a condition at every clock edge.
`define UAPQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define UAPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define UAPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/uapq_pkg.sv]
// ----------------------------------------------------------------------------
// Unsorted array priority queue - package
// Operation and status codes, controller states, field widths and the
// result item type.
// ----------------------------------------------------------------------------
`default_nettype none

package uapq_pkg;

  localparam int DefQueueDepth    = 16;
  localparam int DefValueWidth    = 8;
  localparam int DefPriorityWidth = 16;

  localparam int OpBits        = 2;
  localparam int ValueBits     = 8;
  localparam int PriorityBits  = 16;
  localparam int PositionBits  = 4;
  localparam int StatusBits    = 2;
  localparam int OccupancyBits = 5;

  typedef enum logic [OpBits-1:0] {
    OpInsert  = 2'd0,
    OpPeek    = 2'd1,
    OpExtract = 2'd2,
    OpSetKey  = 2'd3
  } uapq_op_e;

  typedef enum logic [StatusBits-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } uapq_status_e;

  typedef enum logic [1:0] {
    StateIdle,
    StateSearch,
    StateShift
  } uapq_state_e;

  typedef struct packed {
    logic [ValueBits-1:0]     value;
    uapq_status_e             status;
    logic [OccupancyBits-1:0] occupancy;
  } uapq_result_t;

endpackage

`default_nettype wire

[design/uapq_ram.sv]
// ----------------------------------------------------------------------------
// Unsorted array priority queue - slot memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module uapq_ram #(
  parameter int DEPTH = uapq_pkg::DefQueueDepth,
  parameter int WIDTH = uapq_pkg::DefValueWidth,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/uapq_ctrl.sv]
// ----------------------------------------------------------------------------
// Unsorted array priority queue - controller
// Sequencer for insert, set-key, minimum search and compaction over the
// slot memories, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uapq_ctrl #(
  parameter int QUEUE_DEPTH    = uapq_pkg::DefQueueDepth,
  parameter int VALUE_WIDTH    = uapq_pkg::DefValueWidth,
  parameter int PRIORITY_WIDTH = uapq_pkg::DefPriorityWidth,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [uapq_pkg::OpBits-1:0]            operation_i,
  input  wire logic [uapq_pkg::ValueBits-1:0]         item_value_i,
  input  wire logic signed [uapq_pkg::PriorityBits-1:0] item_priority_i,
  input  wire logic [uapq_pkg::PositionBits-1:0]      slot_position_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output uapq_pkg::uapq_result_t                      result_o,
  output logic                                        re_o,
  output logic [AW-1:0]                               raddr_o,
  output logic                                        val_we_o,
  output logic                                        pri_we_o,
  output logic [AW-1:0]                               waddr_o,
  output logic [VALUE_WIDTH-1:0]                      wval_o,
  output logic [PRIORITY_WIDTH-1:0]                   wpri_o,
  input  wire logic [VALUE_WIDTH-1:0]                 rd_val_i,
  input  wire logic signed [PRIORITY_WIDTH-1:0]       rd_pri_i
);

  localparam int XW = (CW > uapq_pkg::PositionBits) ? CW : uapq_pkg::PositionBits;

  uapq_pkg::uapq_state_e state_q, state_d;
  logic                  is_extract_q, is_extract_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         scan_idx_q, scan_idx_d;
  logic signed [PRIORITY_WIDTH-1:0] best_pri_q, best_pri_d;
  logic [VALUE_WIDTH-1:0] best_val_q, best_val_d;
  logic [AW-1:0]         best_idx_q, best_idx_d;
  logic                  out_valid_q, out_valid_d;
  uapq_pkg::uapq_result_t out_q, out_d;

  uapq_pkg::uapq_op_e     op;
  logic [VALUE_WIDTH-1:0] val_in;
  logic signed [PRIORITY_WIDTH-1:0] pri_in;
  logic [XW-1:0]          pos_x;
  logic [XW-1:0]          count_x;
  logic [CW-1:0]          count_last;
  logic                   out_free;
  logic                   cand_take;
  logic signed [PRIORITY_WIDTH-1:0] fin_pri;
  logic [VALUE_WIDTH-1:0] fin_val;
  logic [AW-1:0]          fin_idx;

  assign op         = uapq_pkg::uapq_op_e'(operation_i);
  assign val_in     = VALUE_WIDTH'(item_value_i);
  assign pri_in     = PRIORITY_WIDTH'(item_priority_i);
  assign pos_x      = XW'(slot_position_i);
  assign count_x    = XW'(count_q);
  assign count_last = count_q - CW'(1);
  assign out_free   = !out_valid_q || out_ready_i;

  assign cand_take = (scan_idx_q == '0) || (rd_pri_i < best_pri_q);
  assign fin_pri   = cand_take ? rd_pri_i   : best_pri_q;
  assign fin_val   = cand_take ? rd_val_i   : best_val_q;
  assign fin_idx   = cand_take ? scan_idx_q : best_idx_q;

  always_comb begin
    state_d      = state_q;
    is_extract_d = is_extract_q;
    count_d      = count_q;
    scan_idx_d   = scan_idx_q;
    best_pri_d   = best_pri_q;
    best_val_d   = best_val_q;
    best_idx_d   = best_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    in_ready_o   = 1'b0;
    re_o         = 1'b0;
    raddr_o      = '0;
    val_we_o     = 1'b0;
    pri_we_o     = 1'b0;
    waddr_o      = '0;
    wval_o       = '0;
    wpri_o       = '0;

    unique case (state_q)
      uapq_pkg::StateIdle: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          out_valid_d     = 1'b1;
          out_d.value     = '0;
          out_d.status    = uapq_pkg::StOk;
          out_d.occupancy = uapq_pkg::OccupancyBits'(count_q);
          unique case (op)
            uapq_pkg::OpInsert: begin
              if (count_q == CW'(QUEUE_DEPTH)) begin
                out_d.status = uapq_pkg::StFull;
              end else begin
                val_we_o        = 1'b1;
                pri_we_o        = 1'b1;
                waddr_o         = count_q[AW-1:0];
                wval_o          = val_in;
                wpri_o          = pri_in;
                count_d         = count_q + CW'(1);
                out_d.occupancy = uapq_pkg::OccupancyBits'(count_q + CW'(1));
              end
            end
            uapq_pkg::OpPeek, uapq_pkg::OpExtract: begin
              if (count_q == '0) begin
                out_d.status = uapq_pkg::StEmpty;
              end else begin
                out_valid_d  = 1'b0;
                re_o         = 1'b1;
                raddr_o      = '0;
                scan_idx_d   = '0;
                is_extract_d = (op == uapq_pkg::OpExtract);
                state_d      = uapq_pkg::StateSearch;
              end
            end
            uapq_pkg::OpSetKey: begin
              if (pos_x >= count_x) begin
                out_d.status = uapq_pkg::StRange;
              end else begin
                pri_we_o = 1'b1;
                waddr_o  = pos_x[AW-1:0];
                wpri_o   = pri_in;
              end
            end
          endcase
        end
      end

      uapq_pkg::StateSearch: begin
        best_pri_d = fin_pri;
        best_val_d = fin_val;
        best_idx_d = fin_idx;
        if (CW'(scan_idx_q) == count_last) begin
          out_d.value  = uapq_pkg::ValueBits'(fin_val);
          out_d.status = uapq_pkg::StOk;
          if (!is_extract_q) begin
            out_valid_d     = 1'b1;
            out_d.occupancy = uapq_pkg::OccupancyBits'(count_q);
            state_d         = uapq_pkg::StateIdle;
          end else if (CW'(fin_idx) == count_last) begin
            count_d         = count_last;
            out_valid_d     = 1'b1;
            out_d.occupancy = uapq_pkg::OccupancyBits'(count_last);
            state_d         = uapq_pkg::StateIdle;
          end else begin
            re_o       = 1'b1;
            raddr_o    = fin_idx + AW'(1);
            scan_idx_d = fin_idx;
            state_d    = uapq_pkg::StateShift;
          end
        end else begin
          re_o       = 1'b1;
          raddr_o    = scan_idx_q + AW'(1);
          scan_idx_d = scan_idx_q + AW'(1);
        end
      end

      uapq_pkg::StateShift: begin
        val_we_o = 1'b1;
        pri_we_o = 1'b1;
        waddr_o  = scan_idx_q;
        wval_o   = rd_val_i;
        wpri_o   = rd_pri_i;
        if (CW'(CW'(scan_idx_q) + CW'(1)) == count_last) begin
          count_d         = count_last;
          out_valid_d     = 1'b1;
          out_d.value     = uapq_pkg::ValueBits'(best_val_q);
          out_d.status    = uapq_pkg::StOk;
          out_d.occupancy = uapq_pkg::OccupancyBits'(count_last);
          state_d         = uapq_pkg::StateIdle;
        end else begin
          re_o       = 1'b1;
          raddr_o    = scan_idx_q + AW'(2);
          scan_idx_d = scan_idx_q + AW'(1);
        end
      end

      default: begin
        state_d = uapq_pkg::StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uapq_pkg::StateIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_extract_q <= is_extract_d;
    scan_idx_q   <= scan_idx_d;
    best_pri_q   <= best_pri_d;
    best_val_q   <= best_val_d;
    best_idx_q   <= best_idx_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

[design/unsorted_array_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// Unsorted array priority queue unit
// Bounded priority queue held in insertion order in two slot memories.
// ----------------------------------------------------------------------------
// One item at a time. Insert, set-key and every flagged item (full, empty,
// position out of range) give their result in the cycle after they are taken.
// Peek runs a minimum search that reads one slot per cycle through the single
// read port of the slot memories, which have registered read data. Extract then
// moves each entry after the minimum down one slot through the same port. The
// result sits in an output register; the next item is taken once that register
// is free or being emptied.
`default_nettype none

`include "unsorted_array_priority_queue_unit_defines.svh"

module unsorted_array_priority_queue_unit #(
  parameter int QUEUE_DEPTH    = uapq_pkg::DefQueueDepth,
  parameter int VALUE_WIDTH    = uapq_pkg::DefValueWidth,
  parameter int PRIORITY_WIDTH = uapq_pkg::DefPriorityWidth
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      in_valid_i,
  output logic                                           in_ready_o,
  input  wire logic [uapq_pkg::OpBits-1:0]               operation_i,
  input  wire logic [uapq_pkg::ValueBits-1:0]            item_value_i,
  input  wire logic signed [uapq_pkg::PriorityBits-1:0]  item_priority_i,
  input  wire logic [uapq_pkg::PositionBits-1:0]         slot_position_i,
  output logic                                           out_valid_o,
  input  wire logic                                      out_ready_i,
  output logic [uapq_pkg::ValueBits-1:0]                 result_value_o,
  output logic [uapq_pkg::StatusBits-1:0]                status_o,
  output logic [uapq_pkg::OccupancyBits-1:0]             occupancy_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  uapq_pkg::uapq_result_t result;

  logic                      re;
  logic [AW-1:0]             raddr;
  logic                      val_we;
  logic                      pri_we;
  logic [AW-1:0]             waddr;
  logic [VALUE_WIDTH-1:0]    wval;
  logic [PRIORITY_WIDTH-1:0] wpri;
  logic [VALUE_WIDTH-1:0]    rd_val;
  logic [PRIORITY_WIDTH-1:0] rd_pri;

  uapq_ctrl #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .slot_position_i (slot_position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_o        (result),
    .re_o            (re),
    .raddr_o         (raddr),
    .val_we_o        (val_we),
    .pri_we_o        (pri_we),
    .waddr_o         (waddr),
    .wval_o          (wval),
    .wpri_o          (wpri),
    .rd_val_i        (rd_val),
    .rd_pri_i        (rd_pri)
  );

  uapq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (wval),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_val)
  );

  uapq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (PRIORITY_WIDTH)
  ) u_pri_ram (
    .clk_i   (clk_i),
    .we_i    (pri_we),
    .waddr_i (waddr),
    .wdata_i (wpri),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_pri)
  );

  assign result_value_o = result.value;
  assign status_o       = result.status;
  assign occupancy_o    = result.occupancy;

  `UAPQ_ASSERT_IMPLIES(a_ready_needs_room, clk_i, rst_ni, in_ready_o, !out_valid_o || out_ready_i, "item taken while result register is held")
  `UAPQ_ASSERT_IMPLIES(a_empty_result, clk_i, rst_ni, out_valid_o && (status_o == uapq_pkg::StEmpty), (occupancy_o == '0) && (result_value_o == '0), "empty status with stored entries or value")
  `UAPQ_ASSERT_IMPLIES(a_full_result, clk_i, rst_ni, out_valid_o && (status_o == uapq_pkg::StFull), occupancy_o == uapq_pkg::OccupancyBits'(QUEUE_DEPTH), "full status below depth")
  `UAPQ_ASSERT_NEXT(a_single_cycle_ops, clk_i, rst_ni, in_valid_i && in_ready_o && ((operation_i == uapq_pkg::OpInsert) || (operation_i == uapq_pkg::OpSetKey)), out_valid_o, "insert or set-key result not ready next cycle")

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Unsorted array priority queue unit - testbench
// Runs directed items (empty queue, extreme values and priorities, ties, full
// queue, set-key bounds) and then random operation mixes that swing between
// filling and draining. A predictor tracks the queue contents and every result
// item is checked field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import uapq_pkg::*;

  localparam int QueueSlots  = 16;
  localparam int ResetCycles = 11;
  localparam int StallLimit  = 4000;
  localparam int LongHold    = 120;
  localparam int RandomItems = 1650;
  localparam int CalmItems   = 200;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [OpBits-1:0]           operation_i = '0;
  logic [ValueBits-1:0]        item_value_i = '0;
  logic signed [PriorityBits-1:0] item_priority_i = '0;
  logic [PositionBits-1:0]     slot_position_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [ValueBits-1:0]        result_value_o;
  logic [StatusBits-1:0]       status_o;
  logic [OccupancyBits-1:0]    occupancy_o;

  logic [ValueBits-1:0]           queue_values [QueueSlots];
  logic signed [PriorityBits-1:0] queue_prios  [QueueSlots];
  int                             queue_count = 0;
  uapq_result_t                   pending_results [$];
  int                             mismatch_count = 0;
  logic                           idle_off = 1'b0;
  int                             hold_token = 0;

  unsorted_array_priority_queue_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .slot_position_i (slot_position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_o  (result_value_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic uapq_result_t apply_queue_op(uapq_op_e op, logic [ValueBits-1:0] value,
                                                  logic signed [PriorityBits-1:0] prio,
                                                  logic [PositionBits-1:0] pos);
    uapq_result_t res;
    int best;
    res.value  = '0;
    res.status = StOk;
    case (op)
      OpInsert: begin
        if (queue_count >= QueueSlots) begin
          res.status = StFull;
        end else begin
          queue_values[queue_count] = value;
          queue_prios[queue_count]  = prio;
          queue_count++;
        end
      end
      OpPeek, OpExtract: begin
        if (queue_count == 0) begin
          res.status = StEmpty;
        end else begin
          best = 0;
          for (int i = 1; i < queue_count; i++)
            if (queue_prios[i] < queue_prios[best]) best = i;
          res.value = queue_values[best];
          if (op == OpExtract) begin
            for (int i = best; i < queue_count - 1; i++) begin
              queue_values[i] = queue_values[i+1];
              queue_prios[i]  = queue_prios[i+1];
            end
            queue_count--;
          end
        end
      end
      default: begin
        if (int'(pos) >= queue_count) res.status = StRange;
        else queue_prios[pos] = prio;
      end
    endcase
    res.occupancy = queue_count[OccupancyBits-1:0];
    return res;
  endfunction

  // Call at a rising edge; returns at the edge that accepts the item, valid still high.
  task automatic offer_item(input uapq_op_e op, input logic [ValueBits-1:0] value,
                            input logic signed [PriorityBits-1:0] prio,
                            input logic [PositionBits-1:0] pos);
    int gap;
    gap = 0;
    if (!idle_off && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    item_value_i    <= value;
    item_priority_i <= prio;
    slot_position_i <= pos;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pending_results.push_back(apply_queue_op(op, value, prio, pos));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_item(input int mode);
    int roll;
    uapq_op_e op;
    logic signed [PriorityBits-1:0] prio;
    logic [PositionBits-1:0] pos;
    roll = $urandom_range(0, 99);
    case (mode)
      0: op = (roll < 65) ? OpInsert : (roll < 75) ? OpPeek : (roll < 88) ? OpExtract : OpSetKey;
      1: op = (roll < 20) ? OpInsert : (roll < 35) ? OpPeek : (roll < 85) ? OpExtract : OpSetKey;
      default: op = uapq_op_e'(roll % 4);
    endcase
    roll = $urandom_range(0, 9);
    if (roll < 3) prio = $signed(16'($urandom_range(0, 7)) - 16'sd4);
    else if (roll == 3) prio = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    else prio = $signed(16'($urandom_range(0, 16'hffff)));
    if (queue_count > 0 && $urandom_range(0, 3) != 0)
      pos = 4'($urandom_range(0, queue_count - 1));
    else pos = 4'($urandom_range(0, QueueSlots - 1));
    offer_item(op, 8'($urandom_range(0, 255)), prio, pos);
  endtask

  task automatic test_empty_queue();
    offer_item(OpPeek, 8'h5a, 16'sd0, 4'd0);
    offer_item(OpExtract, 8'ha5, 16'sd0, 4'd0);
    offer_item(OpSetKey, 8'h00, 16'sd7, 4'd0);
    offer_item(OpSetKey, 8'hff, 16'sd7, 4'd15);
  endtask

  task automatic test_extremes_and_ties();
    offer_item(OpInsert, 8'hff, 16'sh7fff, 4'd15);
    offer_item(OpInsert, 8'h00, 16'sh8000, 4'd0);
    offer_item(OpInsert, 8'haa, 16'sh8000, 4'd0);
    offer_item(OpPeek, 8'h00, 16'sd0, 4'd0);
    offer_item(OpSetKey, 8'h00, 16'sd0, 4'd3);
    offer_item(OpSetKey, 8'h00, 16'sh7fff, 4'd2);
    offer_item(OpExtract, 8'h00, 16'sd0, 4'd0);
    offer_item(OpExtract, 8'h00, 16'sd0, 4'd0);
  endtask

  task automatic test_full_queue();
    while (queue_count < QueueSlots)
      offer_item(OpInsert, 8'(queue_count * 17), 16'(queue_count * 100 - 700), 4'd0);
    offer_item(OpInsert, 8'h33, 16'sh8000, 4'd0);
    offer_item(OpSetKey, 8'h00, 16'sh8000, 4'd15);
    offer_item(OpPeek, 8'h00, 16'sd0, 4'd0);
    offer_item(OpExtract, 8'h00, 16'sd0, 4'd0);
    offer_item(OpExtract, 8'h00, 16'sd0, 4'd0);
  endtask

  task automatic test_output_stall();
    hold_token <= hold_token + 1;
    repeat (20) random_item(2);
  endtask

  task automatic test_sender_pause();
    wait_for_results();
    repeat (10) @(posedge clk_i);
    repeat (30) random_item(2);
  endtask

  task automatic test_random_mix();
    int mode;
    mode = 2;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (n == RandomItems - CalmItems) idle_off <= 1'b1;
      random_item(mode);
    end
  endtask

  // Receiver: random stalls plus one long hold per request.
  always @(posedge clk_i) begin : receiver
    int stall_left;
    int hold_seen;
    if (!rst_ni) begin
      stall_left = 0;
      hold_seen  = hold_token;
      out_ready_i <= 1'b0;
    end else begin
      if (hold_seen != hold_token) begin
        hold_seen  = hold_token;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Sample at the falling edge: the handshake completes at the next rising edge.
  always @(negedge clk_i) begin : result_check
    uapq_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item: value %0d status %0d occupancy %0d",
                   result_value_o, status_o, occupancy_o);
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.value || status_o !== want.status ||
            occupancy_o !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: value %0d/%0d status %0d/%0d occupancy %0d/%0d (exp/got)",
                     want.value, result_value_o, want.status, status_o,
                     want.occupancy, occupancy_o);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(negedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_extremes_and_ties();
    test_full_queue();
    test_output_stall();
    test_sender_pause();
    test_random_mix();
    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
